// File: design/qecc_pkg.sv
// Shared types and constants for the quad edge collision check block.
package qecc_pkg;

    localparam int FIELD_BITS   = 16;    // width of each coordinate field on the bus
    localparam int GATE_BITS    = 16;
    localparam int NUM_EDGES    = 4;
    localparam int EDGE_BITS    = 2;
    localparam int NUM_COORDS   = 10;    // corners 0..3 as x,y pairs, then centre x,y
    localparam int CENTER_X     = 8;
    localparam int CENTER_Y     = 9;
    localparam int S_TDATA_BITS = NUM_COORDS * FIELD_BITS;
    localparam int M_TDATA_BITS = 8;

    localparam logic [GATE_BITS-1:0] GATE_RESET = 16'd64;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_TEST = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;    // new test item: forget earlier hits
        logic take;     // lane results valid this cycle
    } merge_ctl_t;

    typedef struct packed {
        logic                 found;
        logic [EDGE_BITS-1:0] side;
    } merge_stat_t;

endpackage

// File: design/qecc_lane.sv
// One edge-pair lane: orientation products, then intersection decision.
module qecc_lane #(
    parameter int CB = 16
) (
    input  logic                 aclk,
    input  logic signed [CB-1:0] e1 [4],    // stored edge: p1x, p1y, q1x, q1y
    input  logic signed [CB-1:0] e2 [4],    // tested edge: p2x, p2y, q2x, q2y
    output logic                 meet
);
    import qecc_pkg::*;

    localparam int DW = CB + 1;
    localparam int PW = 2 * CB + 2;
    localparam int PX = 0;
    localparam int PY = 1;
    localparam int QX = 2;
    localparam int QY = 3;

    localparam logic [1:0] ORI_COL = 2'd0;
    localparam logic [1:0] ORI_CW  = 2'd1;
    localparam logic [1:0] ORI_CCW = 2'd2;

    function automatic logic between(
        input logic signed [CB-1:0] px, input logic signed [CB-1:0] py,
        input logic signed [CB-1:0] qx, input logic signed [CB-1:0] qy,
        input logic signed [CB-1:0] rx, input logic signed [CB-1:0] ry
    );
        logic in_x;
        logic in_y;
        in_x = (qx >= px && qx <= rx) || (qx >= rx && qx <= px);
        in_y = (qy >= py && qy <= ry) || (qy >= ry && qy <= py);
        return in_x && in_y;
    endfunction

    // point triples (p, q, r) of the four orientation tests
    logic signed [CB-1:0] ox [NUM_EDGES][3];
    logic signed [CB-1:0] oy [NUM_EDGES][3];
    logic signed [DW-1:0] da1 [NUM_EDGES];
    logic signed [DW-1:0] da2 [NUM_EDGES];
    logic signed [DW-1:0] db1 [NUM_EDGES];
    logic signed [DW-1:0] db2 [NUM_EDGES];
    logic signed [PW-1:0] pa_next [NUM_EDGES];
    logic signed [PW-1:0] pb_next [NUM_EDGES];
    logic signed [PW-1:0] pa_reg  [NUM_EDGES];
    logic signed [PW-1:0] pb_reg  [NUM_EDGES];
    logic [NUM_EDGES-1:0] bet_next;
    logic [NUM_EDGES-1:0] bet_reg;
    logic [1:0]           ori [NUM_EDGES];
    logic [NUM_EDGES-1:0] col;

    always_comb begin
        ox[0][0] = e1[PX]; oy[0][0] = e1[PY];
        ox[0][1] = e1[QX]; oy[0][1] = e1[QY];
        ox[0][2] = e2[PX]; oy[0][2] = e2[PY];
        ox[1][0] = e1[PX]; oy[1][0] = e1[PY];
        ox[1][1] = e1[QX]; oy[1][1] = e1[QY];
        ox[1][2] = e2[QX]; oy[1][2] = e2[QY];
        ox[2][0] = e2[PX]; oy[2][0] = e2[PY];
        ox[2][1] = e2[QX]; oy[2][1] = e2[QY];
        ox[2][2] = e1[PX]; oy[2][2] = e1[PY];
        ox[3][0] = e2[PX]; oy[3][0] = e2[PY];
        ox[3][1] = e2[QX]; oy[3][1] = e2[QY];
        ox[3][2] = e1[QX]; oy[3][2] = e1[QY];
        for (int k = 0; k < NUM_EDGES; k++) begin
            da1[k] = DW'(oy[k][1]) - DW'(oy[k][0]);
            da2[k] = DW'(ox[k][2]) - DW'(ox[k][1]);
            db1[k] = DW'(ox[k][1]) - DW'(ox[k][0]);
            db2[k] = DW'(oy[k][2]) - DW'(oy[k][1]);
            pa_next[k] = PW'(da1[k]) * PW'(da2[k]);
            pb_next[k] = PW'(db1[k]) * PW'(db2[k]);
            // r lies within the box spanned by p and q
            bet_next[k] = between(ox[k][0], oy[k][0], ox[k][2], oy[k][2],
                                  ox[k][1], oy[k][1]);
        end
    end

    always_ff @(posedge aclk) begin
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
        bet_reg <= bet_next;
    end

    always_comb begin
        for (int k = 0; k < NUM_EDGES; k++) begin
            if (pa_reg[k] == pb_reg[k]) begin
                ori[k] = ORI_COL;
            end else if (pa_reg[k] > pb_reg[k]) begin
                ori[k] = ORI_CW;
            end else begin
                ori[k] = ORI_CCW;
            end
            col[k] = (ori[k] == ORI_COL);
        end
        meet = ((ori[0] != ori[1]) && (ori[2] != ori[3])) || (|(col & bet_reg));
    end

endmodule

// File: design/qecc_gate.sv
// Centre distance gate: squared distance against squared gate value.
module qecc_gate #(
    parameter int CB = 16
) (
    input  logic                           aclk,
    input  logic signed [CB-1:0]           a_cx,
    input  logic signed [CB-1:0]           a_cy,
    input  logic signed [CB-1:0]           b_cx,
    input  logic signed [CB-1:0]           b_cy,
    input  logic [qecc_pkg::GATE_BITS-1:0] gate,
    output logic                           gate_ok
);
    import qecc_pkg::*;

    localparam int DW = CB + 1;
    localparam int SW = 2 * CB + 1;
    localparam int GW = 2 * GATE_BITS;
    localparam int CW = (SW + 1 > GW) ? SW + 1 : GW;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [SW:0]   sqx_full;
    logic signed [SW:0]   sqy_full;
    logic [SW-1:0]        sqx_reg;
    logic [SW-1:0]        sqy_reg;
    logic [GW-1:0]        g2_reg;
    logic [CW-1:0]        d2;
    logic                 gate_ok_reg;

    always_comb begin
        dx       = DW'(b_cx) - DW'(a_cx);
        dy       = DW'(b_cy) - DW'(a_cy);
        sqx_full = (SW+1)'(dx) * (SW+1)'(dx);
        sqy_full = (SW+1)'(dy) * (SW+1)'(dy);
        d2       = CW'(sqx_reg) + CW'(sqy_reg);
    end

    always_ff @(posedge aclk) begin
        sqx_reg     <= sqx_full[SW-1:0];
        sqy_reg     <= sqy_full[SW-1:0];
        g2_reg      <= GW'(gate) * GW'(gate);
        gate_ok_reg <= (d2 < CW'(g2_reg));
    end

    assign gate_ok = gate_ok_reg;

endmodule

// File: design/qecc_merge.sv
// Merge of lane results: keeps the first hit in stored-edge-major order.
module qecc_merge (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  qecc_pkg::merge_ctl_t                ctl,
    input  logic [qecc_pkg::NUM_EDGES-1:0]      meet,
    output qecc_pkg::merge_stat_t               stat
);
    import qecc_pkg::*;

    logic                 found_reg;
    logic                 found_next;
    logic [EDGE_BITS-1:0] side_reg;
    logic [EDGE_BITS-1:0] side_next;
    logic [EDGE_BITS-1:0] first_lane;

    always_comb begin
        first_lane = '0;
        for (int j = NUM_EDGES - 1; j >= 0; j--) begin
            if (meet[j]) begin
                first_lane = EDGE_BITS'(j);
            end
        end
        found_next = found_reg;
        side_next  = side_reg;
        priority if (ctl.clear) begin
            found_next = 1'b0;
            side_next  = '0;
        end else if (ctl.take && !found_reg && (|meet)) begin
            found_next = 1'b1;
            side_next  = first_lane;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            side_reg  <= '0;
        end else begin
            found_reg <= found_next;
            side_reg  <= side_next;
        end
    end

    assign stat.found = found_next;
    assign stat.side  = side_next;

endmodule

// File: design/quad_edge_collision_check_core.sv
// Quad edge collision check: top level with sequencer, box storage and output register.
//
// A load item (s_tuser = 0) stores a four-corner box and its centre and
// gives no result. A test item (s_tuser = 1) carries a second box and gives exactly
// one result item: hit, plus the tested-box edge index of the first intersecting
// edge pair (stored-box edge as outer index, tested-box edge as inner one), or
// hit = 0 and side = 0. A hit is only reported when the squared centre distance
// is strictly below gate_distance squared. Edge k runs from corner k to corner
// (k+1) mod 4; intersection uses the exact orientation test plus the colinear
// on-segment rule. A test item occupies the block from acceptance through the
// ST_SCAN steps, in which four lanes each check one tested-box edge against the
// stored-box edge picked by the scan counter, and the ST_DONE merge step that loads
// the output register (longer only while a previous result is still held by
// m_tready). A load item leaves the block ready, and the output register lets the
// next item be accepted while a result waits. Only the low COORD_BITS bits of each
// coordinate are used, sign extended from bit COORD_BITS-1. gate_distance resets to
// 64 and may only be written while the block is idle; the stored box resets to zero.
module quad_edge_collision_check_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration: gate_distance
    input  logic                                cfg_wr_en,
    input  logic [qecc_pkg::GATE_BITS-1:0]      cfg_wr_data,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
    // corner3_x, corner3_y, center_x, center_y (16 bits each)
    input  logic [qecc_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // cmd
    input  logic [0:0]                          s_tuser,
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit, side[1:0], zero padding
    output logic [qecc_pkg::M_TDATA_BITS-1:0]   m_tdata
);
    import qecc_pkg::*;

    localparam int CB = COORD_BITS;

    // take low CB bits of a zero-extended field
    function automatic logic signed [CB-1:0] to_coord(input logic [FIELD_BITS-1:0] f);
        logic [2*FIELD_BITS+CB-1:0] w;
        w = (2*FIELD_BITS+CB)'(f);
        return w[CB-1:0];
    endfunction

    state_t               state_reg;
    state_t               state_next;
    logic [EDGE_BITS-1:0] cnt_reg;
    logic [EDGE_BITS-1:0] cnt_next;
    logic                 s1_valid_reg;
    logic                 in_accept;
    logic                 test_accept;
    logic                 load_accept;
    logic                 out_load;

    logic signed [CB-1:0] in_coord [NUM_COORDS];
    logic signed [CB-1:0] a_reg    [NUM_COORDS];    // stored box
    logic signed [CB-1:0] b_reg    [NUM_COORDS];    // box under test
    logic [GATE_BITS-1:0] gate_reg;

    // stored-box edge per scan step, picked by the scan counter
    logic signed [CB-1:0] cand     [NUM_EDGES][4];
    logic signed [CB-1:0] st_edge  [4];
    logic signed [CB-1:0] tb_edge  [NUM_EDGES][4];
    logic [NUM_EDGES-1:0] meet;
    logic                 gate_ok;

    merge_ctl_t           mctl;
    merge_stat_t          mstat;

    logic                 m_tvalid_reg;
    logic                 hit_reg;
    logic [EDGE_BITS-1:0] side_reg;

    // ---------------------------------------------------------------- input side
    assign s_tready    = (state_reg == ST_IDLE);
    assign in_accept   = s_tvalid && s_tready;
    assign test_accept = in_accept && (s_tuser[0] == CMD_TEST);
    assign load_accept = in_accept && (s_tuser[0] == CMD_LOAD);

    always_comb begin
        for (int k = 0; k < NUM_COORDS; k++) begin
            in_coord[k] = to_coord(s_tdata[k*FIELD_BITS +: FIELD_BITS]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_COORDS; k++) begin
                a_reg[k] <= '0;
            end
            gate_reg <= GATE_RESET;
        end else begin
            if (load_accept) begin
                a_reg <= in_coord;
            end
            if (cfg_wr_en) begin
                gate_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (test_accept) begin
            b_reg <= in_coord;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            s1_valid_reg <= (state_reg == ST_SCAN);
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (test_accept) begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == EDGE_BITS'(NUM_EDGES - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // last lane results merge this cycle; wait for a free output slot
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mctl.clear = test_accept;
    assign mctl.take  = s1_valid_reg;

    // ---------------------------------------------------------------- edge lanes
    always_comb begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            cand[e][0] = a_reg[2*e];
            cand[e][1] = a_reg[2*e+1];
            cand[e][2] = a_reg[2*((e+1) % NUM_EDGES)];
            cand[e][3] = a_reg[2*((e+1) % NUM_EDGES)+1];
            tb_edge[e][0] = b_reg[2*e];
            tb_edge[e][1] = b_reg[2*e+1];
            tb_edge[e][2] = b_reg[2*((e+1) % NUM_EDGES)];
            tb_edge[e][3] = b_reg[2*((e+1) % NUM_EDGES)+1];
        end
        st_edge = cand[cnt_reg];
    end

    for (genvar j = 0; j < NUM_EDGES; j++) begin : g_lane
        qecc_lane #(
            .CB (CB)
        ) u_lane (
            .aclk (aclk),
            .e1   (st_edge),
            .e2   (tb_edge[j]),
            .meet (meet[j])
        );
    end

    qecc_gate #(
        .CB (CB)
    ) u_gate (
        .aclk    (aclk),
        .a_cx    (a_reg[CENTER_X]),
        .a_cy    (a_reg[CENTER_Y]),
        .b_cx    (b_reg[CENTER_X]),
        .b_cy    (b_reg[CENTER_Y]),
        .gate    (gate_reg),
        .gate_ok (gate_ok)
    );

    qecc_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mctl),
        .meet    (meet),
        .stat    (mstat)
    );

    // ---------------------------------------------------------------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            hit_reg  <= mstat.found && gate_ok;
            side_reg <= (mstat.found && gate_ok) ? mstat.side : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'({side_reg, hit_reg});

endmodule

// File: design/qecc_checker.sv
// Port-level checks for the quad edge collision check core, with bind.
module qecc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [0:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // held result must not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a miss always reports edge 0
    a_miss_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == 2'd0)
        else $error("side nonzero without hit");

    // a test item occupies the block
    a_test_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("accepted item during test");

    // a load item leaves the input ready
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
        else $error("load blocked input");

endmodule

bind quad_edge_collision_check_core qecc_checker u_qecc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
